@@ rtl/twhsr_pkg.sv @@
// package: sequencer step codes, start pattern tables and field widths
package twhsr_pkg;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'd0,
        ST_START0    = 5'd1,
        ST_START1    = 5'd2,
        ST_START2    = 5'd3,
        ST_START3    = 5'd4,
        ST_START4    = 5'd5,
        ST_START5    = 5'd6,
        ST_START6    = 5'd7,
        ST_SEND_A    = 5'd8,
        ST_SEND_B    = 5'd9,
        ST_SEND_C    = 5'd10,
        ST_ACK_WAIT  = 5'd11,
        ST_ACK_CLK   = 5'd12,
        ST_ACK_FALL  = 5'd13,
        ST_MEAS_WAIT = 5'd14,
        ST_READ_LOW  = 5'd15,
        ST_READ_HIGH = 5'd16,
        ST_RACK_HIGH = 5'd17,
        ST_RACK_LOW  = 5'd18
    } step_t;

    // configuration register indexes
    typedef enum logic {
        REG_TEMP_CMD = 1'b0,
        REG_HUM_CMD  = 1'b1
    } cfg_reg_t;

    // start pattern, entry i is used in start step i
    localparam logic [0:6] START_CLK = 7'b0110110;
    localparam logic [0:6] START_DAT = 7'b1100011;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned DATA_BYTES    = 2;
    localparam int unsigned IN_TDATA_W    = 8;
    localparam int unsigned OUT_TDATA_W   = 40;
    localparam int unsigned WORD_W        = 16;

endpackage

@@ rtl/two_wire_humidity_sensor_reader_top.sv @@
// top level: tick-driven bit-banged master for a two-wire humidity sensor
//
//  channel  | signals                           | role
//  ---------+-----------------------------------+--------------------------------
//  s_axis   | s_tvalid s_tready s_tdata[7:0]    | one timing tick per transfer
//  m_axis   | m_tvalid m_tready m_tdata[39:0]   | line levels and words per tick
//           | m_tlast                           | run finished on this tick
//  cfg      | cfg_valid cfg_ready cfg_index     | command byte registers
//           | cfg_data[7:0]                     |
//
// on every tick the sequencer step, counters and shift byte are updated by
// a single step of logic and the result lands in the output register in
// the same edge; a new tick is taken every cycle while the output register
// is empty or being drained. reset puts the sequencer in idle with both
// words cleared and the commands at 3 and 5. a stall on the output side
// holds the result and stops input transfers; nothing is lost.
module two_wire_humidity_sensor_reader_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: [0] start_request, [1] measure_mode, [2] data_line_in, rest zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [twhsr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: [0] clock_line, [1] data_line_out, [2] data_drive_enable,
    // [3] busy_res, [19:4] temperature_raw, [35:20] humidity_raw,
    // [36] humidity_valid, rest zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [twhsr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // m_tlast: run_done
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data
);
    import twhsr_pkg::*;

    // configuration
    logic [7:0] temp_cmd_reg;
    logic [7:0] hum_cmd_reg;

    // sequencer state
    step_t               step_reg, step_next;
    logic [3:0]          bit_cnt_reg, bit_cnt_next;
    logic [1:0]          byte_cnt_reg, byte_cnt_next;
    logic [7:0]          shift_reg, shift_next;
    logic                meas_hum_reg, meas_hum_next;
    logic                mode_reg, mode_next;
    logic [WORD_W-1:0]   temp_word_reg, temp_word_next;
    logic [WORD_W-1:0]   hum_word_reg, hum_word_next;

    // output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic       in_fire;
    logic       start_req, meas_mode, din;
    step_t      step_cur;
    logic [2:0] start_idx;
    logic [3:0] bit_inc;
    logic       clk_o, dout_o, den_o, done_o;

    assign start_req = s_tdata[0];
    assign meas_mode = s_tdata[1];
    assign din       = s_tdata[2];

    // output register frees up in the same cycle it is drained
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign start_idx = 3'(step_cur - ST_START0);
    assign bit_inc   = bit_cnt_reg + 4'd1;

    // one sequencer step per tick
    always_comb
    begin
        step_cur      = step_reg;
        mode_next     = mode_reg;
        meas_hum_next = meas_hum_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next    = shift_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        clk_o  = 1'b0;
        dout_o = 1'b0;
        den_o  = 1'b0;
        done_o = 1'b0;

        // codes outside the step list behave as idle
        if (!(step_reg inside {[ST_START0:ST_RACK_LOW]}))
        begin
            step_cur = ST_IDLE;
            if (start_req)
            begin
                mode_next     = meas_mode;
                meas_hum_next = 1'b0;
                step_cur      = ST_START0;
            end
        end
        step_next = step_cur;

        case (step_cur)
            ST_START0, ST_START1, ST_START2, ST_START3, ST_START4, ST_START5:
            begin
                clk_o     = START_CLK[start_idx];
                dout_o    = START_DAT[start_idx];
                den_o     = 1'b1;
                step_next = step_t'(step_cur + 5'd1);
            end
            ST_START6:
            begin
                clk_o        = START_CLK[start_idx];
                dout_o       = START_DAT[start_idx];
                den_o        = 1'b1;
                shift_next   = meas_hum_next ? hum_cmd_reg : temp_cmd_reg;
                bit_cnt_next = 4'd0;
                step_next    = ST_SEND_A;
            end
            ST_SEND_A:
            begin
                dout_o    = shift_reg[7];
                den_o     = 1'b1;
                step_next = ST_SEND_B;
            end
            ST_SEND_B:
            begin
                dout_o    = shift_reg[7];
                den_o     = 1'b1;
                step_next = ST_SEND_C;
            end
            ST_SEND_C:
            begin
                dout_o     = shift_reg[7];
                den_o      = 1'b1;
                clk_o      = 1'b1;
                shift_next = {shift_reg[6:0], 1'b0};
                if (bit_inc >= 4'(BITS_PER_BYTE))
                begin
                    bit_cnt_next = 4'd0;
                    step_next    = ST_ACK_WAIT;
                end
                else
                begin
                    bit_cnt_next = bit_inc;
                    step_next    = ST_SEND_A;
                end
            end
            ST_ACK_WAIT:
            begin
                // sensor pulls data low to acknowledge
                if (!din)
                    step_next = ST_ACK_CLK;
            end
            ST_ACK_CLK:
            begin
                clk_o     = 1'b1;
                step_next = ST_ACK_FALL;
            end
            ST_ACK_FALL:
            begin
                step_next = ST_MEAS_WAIT;
            end
            ST_MEAS_WAIT:
            begin
                if (!din)
                begin
                    bit_cnt_next  = 4'd0;
                    byte_cnt_next = 2'd0;
                    shift_next    = 8'd0;
                    step_next     = ST_READ_LOW;
                end
            end
            ST_READ_LOW:
            begin
                step_next = ST_READ_HIGH;
            end
            ST_READ_HIGH:
            begin
                clk_o      = 1'b1;
                shift_next = {shift_reg[6:0], din};
                if (bit_inc >= 4'(BITS_PER_BYTE))
                begin
                    bit_cnt_next = 4'd0;
                    step_next    = ST_RACK_HIGH;
                end
                else
                begin
                    bit_cnt_next = bit_inc;
                    step_next    = ST_READ_LOW;
                end
            end
            ST_RACK_HIGH:
            begin
                clk_o     = 1'b1;
                den_o     = 1'b1;
                step_next = ST_RACK_LOW;
            end
            ST_RACK_LOW:
            begin
                den_o = 1'b1;
                if (byte_cnt_reg < 2'(DATA_BYTES))
                begin
                    if (meas_hum_reg)
                        hum_word_next = {hum_word_reg[7:0], shift_reg};
                    else
                        temp_word_next = {temp_word_reg[7:0], shift_reg};
                    byte_cnt_next = byte_cnt_reg + 2'd1;
                    shift_next    = 8'd0;
                    step_next     = ST_READ_LOW;
                end
                else
                begin
                    // check byte done: repeat for humidity or finish
                    byte_cnt_next = 2'd0;
                    shift_next    = 8'd0;
                    if (!meas_hum_reg && mode_reg)
                    begin
                        meas_hum_next = 1'b1;
                        step_next     = ST_START0;
                    end
                    else
                    begin
                        meas_hum_next = 1'b0;
                        done_o        = 1'b1;
                        step_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    // result packing
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = clk_o;
        out_data_next[1]     = den_o & dout_o;
        out_data_next[2]     = den_o;
        out_data_next[3]     = (step_next != ST_IDLE);
        out_data_next[19:4]  = temp_word_next;
        out_data_next[35:20] = hum_word_next;
        out_data_next[36]    = (step_next == ST_IDLE) & mode_next;
        out_last_next        = done_o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cmd_reg <= 8'd3;
            hum_cmd_reg  <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEMP_CMD: temp_cmd_reg <= cfg_data;
                REG_HUM_CMD:  hum_cmd_reg  <= cfg_data;
                default:      temp_cmd_reg <= temp_cmd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            bit_cnt_reg   <= 4'd0;
            byte_cnt_reg  <= 2'd0;
            shift_reg     <= 8'd0;
            meas_hum_reg  <= 1'b0;
            mode_reg      <= 1'b0;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
        end
        else if (in_fire)
        begin
            step_reg      <= step_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            shift_reg     <= shift_next;
            meas_hum_reg  <= meas_hum_next;
            mode_reg      <= mode_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/twhsr_checker.sv @@
// checker: port-level properties of the sensor reader, bound to the top level
module twhsr_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [twhsr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                                m_tlast
);
    import twhsr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // input side is open exactly when the output register can take a result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register");

    // a finished run leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[3])
        else $error("run done while still busy");

    // humidity flag only shows while idle
    a_hv_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[36])
        else $error("humidity valid while busy");

    // a released data line is never driven high
    a_released: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[2])
        else $error("data high without drive enable");

endmodule

bind two_wire_humidity_sensor_reader_top twhsr_checker u_twhsr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
